// ===== rtl/core/pfe_pkg.sv =====
// Shared constants and types of the postfix expression evaluator.
package pfe_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ENTRIES_W   = 6;
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP1,
    ST_WAIT1,
    ST_POP2,
    ST_WAIT2,
    ST_CALC,
    ST_DIV,
    ST_PUSH,
    ST_FPOP,
    ST_FWAIT,
    ST_EMIT
  } pfe_state_e;

  typedef struct packed {
    logic              done;
    logic              div_zero;
    logic [DATA_W-1:0] quot;
  } pfe_div_res_t;

endpackage

// ===== rtl/core/pfe_div.sv =====
// Bit-serial signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
module pfe_div import pfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DATA_W-1:0]  num_i,
  input  logic [DATA_W-1:0]  den_i,
  output pfe_div_res_t       res_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 neg_q;
  logic                 dz_q;
  logic [DATA_W-1:0]    quo_q;
  logic [DATA_W-1:0]    rem_q;
  logic [DATA_W-1:0]    den_q;
  logic [DATA_W-1:0]    un;
  logic [DATA_W-1:0]    ud;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;

  assign un    = num_i[DATA_W-1] ? (DATA_W'(0) - num_i) : num_i;
  assign ud    = den_i[DATA_W-1] ? (DATA_W'(0) - den_i) : den_i;
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      if (ud == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = DIV_CNT_W'(DATA_W - 1);
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      rem_q <= '0;
      den_q <= ud;
      dz_q  <= (ud == '0);
      quo_q <= (ud == '0) ? '0 : un;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign res_o.done     = done_q;
  assign res_o.div_zero = dz_q;
  assign res_o.quot     = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

// ===== rtl/core/postfix_expression_evaluator.sv =====
// Top level of the postfix expression evaluator: operand stack memory and sequencer.
//
// Input channel (in_valid_i/in_ready_o) takes one expression character per item
// together with end_of_expr_i. Output channel (out_valid_o/out_ready_i) gives one
// item per expression: the popped top word, the sticky error flags and the
// number of stack entries left.
// One item is processed at a time; in_ready_o is high only while the sequencer
// waits for an item. A digit is one write to the stack memory. An operator takes
// two pops, each a synchronous read of the stack memory, then the operation and
// the write-back push. A division runs in the bit-serial divider, one quotient
// bit per cycle, which skips the serial steps for a zero divisor. The last item
// adds the final pop and the load of the output register.
// The output register holds a result until it is taken; the block keeps taking
// items meanwhile and stalls only when a new result finds it still full.
// Reset empties the stack and clears the flags; stack memory contents are not
// cleared, since only written entries are ever read.
module postfix_expression_evaluator import pfe_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [SYM_W-1:0]            symbol_i,
  input  logic                        end_of_expr_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DATA_W-1:0]    result_value_o,
  output logic                        underflow_seen_o,
  output logic                        overflow_seen_o,
  output logic                        div_zero_seen_o,
  output logic [ENTRIES_W-1:0]        entries_left_o
);

  pfe_state_e           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 uf_q, uf_d;
  logic                 of_q, of_d;
  logic                 dz_q, dz_d;
  logic                 out_valid_q, out_valid_d;
  logic [SYM_W-1:0]     sym_q, sym_d;
  logic                 last_q, last_d;
  logic [DATA_W-1:0]    opa_q, opa_d;
  logic [DATA_W-1:0]    opb_q, opb_d;
  logic [DATA_W-1:0]    res_q, res_d;
  logic [DATA_W-1:0]    out_val_q;
  logic                 out_uf_q, out_of_q, out_dz_q;
  logic [ENTRIES_W-1:0] out_cnt_q;

  logic [DATA_W-1:0]    stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0]    rd_data_q;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [DATA_W-1:0]    mem_wdata;

  logic                 in_acc;
  logic                 in_digit;
  logic                 cnt_empty;
  logic                 cnt_full;
  logic                 load_out;
  logic                 div_start;
  logic [SYM_W-1:0]     digit_val;
  logic [CNT_W-1:0]     cnt_dec;
  pfe_div_res_t         div_res;

  assign in_acc    = in_valid_i && in_ready_o;
  assign in_digit  = (symbol_i >= SYM_ZERO) && (symbol_i <= SYM_NINE);
  assign digit_val = symbol_i - SYM_ZERO;
  assign cnt_empty = (cnt_q == '0);
  assign cnt_full  = (cnt_q >= CNT_W'(STACK_DEPTH));
  assign cnt_dec   = cnt_q - CNT_W'(1);
  assign rd_addr   = cnt_dec[ADDR_W-1:0];
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_digit) begin
            state_d = ST_POP1;
          end else if (end_of_expr_i) begin
            state_d = ST_FPOP;
          end
        end
      end
      ST_POP1:  state_d = cnt_empty ? ST_POP2 : ST_WAIT1;
      ST_WAIT1: state_d = ST_POP2;
      ST_POP2:  state_d = cnt_empty ? ST_CALC : ST_WAIT2;
      ST_WAIT2: state_d = ST_CALC;
      ST_CALC:  state_d = (sym_q == SYM_DIV) ? ST_DIV : ST_PUSH;
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH:  state_d = last_q ? ST_FPOP : ST_IDLE;
      ST_FPOP:  state_d = cnt_empty ? ST_EMIT : ST_FWAIT;
      ST_FWAIT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    uf_d      = uf_q;
    of_d      = of_q;
    dz_d      = dz_q;
    sym_d     = sym_q;
    last_d    = last_q;
    opa_d     = opa_q;
    opb_d     = opb_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[ADDR_W-1:0];
    mem_wdata = res_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sym_d  = symbol_i;
          last_d = end_of_expr_i;
          if (in_digit) begin
            if (cnt_full) begin
              of_d = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = DATA_W'(digit_val);
              cnt_d     = cnt_q + CNT_W'(1);
            end
          end
        end
      end
      ST_POP1: begin
        if (cnt_empty) begin
          uf_d  = 1'b1;
          opa_d = '0;
        end else begin
          cnt_d = cnt_dec;
        end
      end
      ST_WAIT1: opa_d = rd_data_q;
      ST_POP2: begin
        if (cnt_empty) begin
          uf_d  = 1'b1;
          opb_d = '0;
        end else begin
          cnt_d = cnt_dec;
        end
      end
      ST_WAIT2: opb_d = rd_data_q;
      ST_CALC: begin
        priority if (sym_q == SYM_PLUS) begin
          res_d = opb_q + opa_q;
        end else if (sym_q == SYM_MINUS) begin
          res_d = opb_q - opa_q;
        end else if (sym_q == SYM_MUL) begin
          res_d = opb_q * opa_q;
        end else if (sym_q == SYM_DIV) begin
          div_start = 1'b1;
        end else begin
          res_d = '0;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          res_d = div_res.quot;
          dz_d  = dz_q | div_res.div_zero;
        end
      end
      ST_PUSH: begin
        if (cnt_full) begin
          of_d = 1'b1;
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      ST_FPOP: begin
        if (cnt_empty) begin
          uf_d  = 1'b1;
          res_d = '0;
        end else begin
          cnt_d = cnt_dec;
        end
      end
      ST_FWAIT: res_d = rd_data_q;
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          cnt_d    = '0;
          uf_d     = 1'b0;
          of_d     = 1'b0;
          dz_d     = 1'b0;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      uf_q        <= 1'b0;
      of_q        <= 1'b0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      uf_q        <= uf_d;
      of_q        <= of_d;
      dz_q        <= dz_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    last_q <= last_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    res_q  <= res_d;
    if (load_out) begin
      out_val_q <= res_q;
      out_uf_q  <= uf_q;
      out_of_q  <= of_q;
      out_dz_q  <= dz_q;
      out_cnt_q <= ENTRIES_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  pfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (opb_q),
    .den_i   (opa_q),
    .res_o   (div_res)
  );

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = $signed(out_val_q);
  assign underflow_seen_o = out_uf_q;
  assign overflow_seen_o  = out_of_q;
  assign div_zero_seen_o  = out_dz_q;
  assign entries_left_o   = out_cnt_q;

endmodule

// ===== sim/postfix_result_checker.sv =====
// Checker for the postfix expression evaluator: predicts each expression result and compares.
module postfix_result_checker import pfe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [SYM_W-1:0]     symbol_i,
  input  logic                 end_of_expr_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [DATA_W-1:0]    result_value_i,
  input  logic                 underflow_seen_i,
  input  logic                 overflow_seen_i,
  input  logic                 div_zero_seen_i,
  input  logic [ENTRIES_W-1:0] entries_left_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   items_o,
  output int                   results_o,
  output int                   underflows_o,
  output int                   overflows_o,
  output int                   div_zeros_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0]    value;
    logic                 underflow;
    logic                 overflow;
    logic                 div_zero;
    logic [ENTRIES_W-1:0] left;
  } expr_result_t;

  logic [DATA_W-1:0] operand_words [STACK_DEPTH];
  int unsigned       operand_count;
  logic              underflow_flag, overflow_flag, div_zero_flag;
  expr_result_t      results_due [$];
  int                mismatches, items_seen, results_seen;
  int                underflow_exprs, overflow_exprs, div_zero_exprs;

  function automatic logic [DATA_W-1:0] pop_operand();
    if (operand_count == 0) begin
      underflow_flag = 1'b1;
      return '0;
    end
    operand_count--;
    return operand_words[operand_count];
  endfunction

  function automatic void push_operand(input logic [DATA_W-1:0] word);
    if (operand_count >= STACK_DEPTH) begin
      overflow_flag = 1'b1;
      return;
    end
    operand_words[operand_count] = word;
    operand_count++;
  endfunction

  function automatic logic [DATA_W-1:0] truncated_quotient(input logic [DATA_W-1:0] num,
                                                           input logic [DATA_W-1:0] den);
    logic [DATA_W-1:0] num_mag, den_mag, quot;
    num_mag = num[DATA_W-1] ? -num : num;
    den_mag = den[DATA_W-1] ? -den : den;
    if (den_mag == '0) begin
      div_zero_flag = 1'b1;
      return '0;
    end
    quot = num_mag / den_mag;
    return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quot : quot;
  endfunction

  function automatic logic [DATA_W-1:0] combine(input logic [DATA_W-1:0] second,
                                                input logic [DATA_W-1:0] first,
                                                input logic [SYM_W-1:0] sym);
    case (sym)
      SYM_PLUS:  return second + first;
      SYM_MINUS: return second - first;
      SYM_MUL:   return second * first;
      SYM_DIV:   return truncated_quotient(second, first);
      default:   return '0;
    endcase
  endfunction

  function automatic void evaluate_symbol(input logic [SYM_W-1:0] sym, input logic last);
    logic [DATA_W-1:0] first, second;
    expr_result_t      res;
    if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
      push_operand(DATA_W'(sym - SYM_ZERO));
    end else begin
      first  = pop_operand();
      second = pop_operand();
      push_operand(combine(second, first, sym));
    end
    if (last) begin
      res.value     = pop_operand();
      res.underflow = underflow_flag;
      res.overflow  = overflow_flag;
      res.div_zero  = div_zero_flag;
      res.left      = operand_count[ENTRIES_W-1:0];
      results_due.push_back(res);
      if (res.underflow) underflow_exprs++;
      if (res.overflow) overflow_exprs++;
      if (res.div_zero) div_zero_exprs++;
      operand_count  = 0;
      underflow_flag = 1'b0;
      overflow_flag  = 1'b0;
      div_zero_flag  = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("MISMATCH %s: got %0h, expected %0h (result %0d, %0t)",
             what, got, want, results_seen, $realtime);
    mismatches++;
  endtask

  task automatic check_result();
    expr_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with no expression pending", result_value_i, '0);
      return;
    end
    want = results_due.pop_front();
    results_seen++;
    if (result_value_i !== want.value)
      report_mismatch("result_value", result_value_i, want.value);
    if (underflow_seen_i !== want.underflow)
      report_mismatch("underflow_seen", DATA_W'(underflow_seen_i), DATA_W'(want.underflow));
    if (overflow_seen_i !== want.overflow)
      report_mismatch("overflow_seen", DATA_W'(overflow_seen_i), DATA_W'(want.overflow));
    if (div_zero_seen_i !== want.div_zero)
      report_mismatch("div_zero_seen", DATA_W'(div_zero_seen_i), DATA_W'(want.div_zero));
    if (entries_left_i !== want.left)
      report_mismatch("entries_left", DATA_W'(entries_left_i), DATA_W'(want.left));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      operand_count  = 0;
      underflow_flag = 1'b0;
      overflow_flag  = 1'b0;
      div_zero_flag  = 1'b0;
      results_due.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        items_seen++;
        evaluate_symbol(symbol_i, end_of_expr_i);
      end
      if (out_valid_i && out_ready_i) check_result();
    end
    fail_count_o <= mismatches;
    pending_o    <= results_due.size();
    items_o      <= items_seen;
    results_o    <= results_seen;
    underflows_o <= underflow_exprs;
    overflows_o  <= overflow_exprs;
    div_zeros_o  <= div_zero_exprs;
  end

endmodule

// ===== sim/postfix_expression_evaluator_tb.sv =====
// Testbench top for the postfix expression evaluator: clock, reset, stimulus and verdict.
module postfix_expression_evaluator_tb import pfe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [SYM_W-1:0] SYM_NUL      = 8'h00;
  localparam logic [SYM_W-1:0] SYM_ALL_ONES = 8'hFF;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [SYM_W-1:0]         symbol_i;
  logic                     end_of_expr_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] result_value_o;
  logic                     underflow_seen_o;
  logic                     overflow_seen_o;
  logic                     div_zero_seen_o;
  logic [ENTRIES_W-1:0]     entries_left_o;

  int fail_count, pending, items_checked, results_checked;
  int underflows, overflows, div_zeros;
  int items_sent = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 71;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always #5 clk_i = ~clk_i;

  postfix_expression_evaluator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .symbol_i         (symbol_i),
    .end_of_expr_i    (end_of_expr_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_value_o   (result_value_o),
    .underflow_seen_o (underflow_seen_o),
    .overflow_seen_o  (overflow_seen_o),
    .div_zero_seen_o  (div_zero_seen_o),
    .entries_left_o   (entries_left_o)
  );

  postfix_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .symbol_i         (symbol_i),
    .end_of_expr_i    (end_of_expr_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_value_i   (result_value_o),
    .underflow_seen_i (underflow_seen_o),
    .overflow_seen_i  (overflow_seen_o),
    .div_zero_seen_i  (div_zero_seen_o),
    .entries_left_i   (entries_left_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .items_o          (items_checked),
    .results_o        (results_checked),
    .underflows_o     (underflows),
    .overflows_o      (overflows),
    .div_zeros_o      (div_zeros)
  );

  // hold off the result channel on request, otherwise stall at random
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [SYM_W-1:0] digit_sym(input int unsigned v);
    return SYM_ZERO + v[SYM_W-1:0];
  endfunction

  function automatic logic [SYM_W-1:0] pick_operator();
    logic [SYM_W-1:0] sym;
    if ($urandom_range(9) != 0) begin
      case ($urandom_range(3))
        0:       return SYM_PLUS;
        1:       return SYM_MINUS;
        2:       return SYM_MUL;
        default: return SYM_DIV;
      endcase
    end
    do sym = SYM_W'($urandom_range(255)); while (sym >= SYM_ZERO && sym <= SYM_NINE);
    return sym;
  endfunction

  task automatic offer(input logic [SYM_W-1:0] sym, input logic last);
    in_valid_i    <= 1'b1;
    symbol_i      <= sym;
    end_of_expr_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random_expr();
    int len, depth;
    len   = $urandom_range(1, 14);
    depth = 0;
    for (int i = 0; i < len; i++) begin
      if (depth >= 2 && ($urandom_range(1) == 1 || depth > 5)) begin
        offer(pick_operator(), i == len - 1);
        depth--;
      end else begin
        offer(digit_sym($urandom_range(9)), i == len - 1);
        depth++;
      end
    end
  endtask

  task automatic send_product_chain();
    int steps;
    steps = $urandom_range(4, 14);
    offer(digit_sym($urandom_range(2, 9)), 1'b0);
    repeat (steps) begin
      offer(digit_sym($urandom_range(2, 9)), 1'b0);
      offer(SYM_MUL, 1'b0);
    end
    offer(digit_sym($urandom_range(9)), 1'b0);
    offer(pick_operator(), 1'b1);
  endtask

  // build the most negative word as 8^10 * 2, then divide or adjust it
  task automatic send_extreme_quotient();
    offer(digit_sym(8), 1'b0);
    repeat (9) begin
      offer(digit_sym(8), 1'b0);
      offer(SYM_MUL, 1'b0);
    end
    offer(digit_sym(2), 1'b0);
    offer(SYM_MUL, 1'b0);
    case ($urandom_range(2))
      0: begin
        offer(digit_sym(0), 1'b0);
        offer(digit_sym(1), 1'b0);
        offer(SYM_MINUS, 1'b0);
        offer(SYM_DIV, 1'b1);
      end
      1: begin
        offer(digit_sym(0), 1'b0);
        offer(SYM_DIV, 1'b1);
      end
      default: begin
        offer(digit_sym(1), 1'b0);
        offer(SYM_MINUS, 1'b1);
      end
    endcase
  endtask

  task automatic send_deep_fill();
    int pushes, ops;
    pushes = $urandom_range(30, 36);
    ops    = $urandom_range(0, 3);
    for (int i = 0; i < pushes; i++) begin
      offer(digit_sym($urandom_range(9)), ops == 0 && i == pushes - 1);
    end
    for (int i = 0; i < ops; i++) offer(pick_operator(), i == ops - 1);
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      offer(SYM_W'($urandom_range(255)), i == len - 1 || $urandom_range(7) == 0);
    end
  endtask

  task automatic run_phase(input int upto);
    int pick;
    while (items_sent < upto) begin
      pick = $urandom_range(99);
      if (pick < 60) send_random_expr();
      else if (pick < 72) send_product_chain();
      else if (pick < 78) send_extreme_quotient();
      else if (pick < 84) send_deep_fill();
      else send_noise();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    symbol_i      = '0;
    end_of_expr_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(SYM_NUL, 1'b1);
    offer(digit_sym(9), 1'b1);
    offer(digit_sym(0), 1'b1);
    offer(digit_sym(7), 1'b0);
    offer(digit_sym(3), 1'b0);
    offer(SYM_MINUS, 1'b1);
    offer(digit_sym(2), 1'b0);
    offer(digit_sym(9), 1'b0);
    offer(SYM_MINUS, 1'b0);
    offer(digit_sym(9), 1'b0);
    offer(SYM_MUL, 1'b1);
    offer(digit_sym(0), 1'b0);
    offer(digit_sym(7), 1'b0);
    offer(SYM_MINUS, 1'b0);
    offer(digit_sym(2), 1'b0);
    offer(SYM_DIV, 1'b1);
    offer(digit_sym(5), 1'b0);
    offer(digit_sym(0), 1'b0);
    offer(SYM_DIV, 1'b1);
    offer(digit_sym(3), 1'b0);
    offer(digit_sym(4), 1'b0);
    offer(SYM_ALL_ONES, 1'b1);
    offer(digit_sym(6), 1'b0);
    offer(digit_sym(4), 1'b0);
    offer(SYM_PLUS, 1'b0);
    offer(digit_sym(8), 1'b1);

    run_phase(575);
    drain();
    send_idle_pct <= 71;
    recv_idle_pct <= 13;
    run_phase(1125);
    drain();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_requests <= hold_requests + 1;
    run_phase(1650);
    drain();
    repeat (100) @(posedge clk_i);

    $display("Checked %0d expression results from %0d items in %0d cycles",
             results_checked, items_checked, cycle_count);
    $display("Results flagged: underflow %0d, overflow %0d, divide by zero %0d",
             underflows, overflows, div_zeros);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
